@@ hw/rtl/sdssp_pkg.sv @@
// Shared types, constants and segment lookup for the seven-segment packer.
package sdssp_pkg;

  // Number of digit positions on the display
  localparam int NUM_POS = 7;
  localparam int SEG_W   = 7;
  localparam int SEGS_W  = NUM_POS * SEG_W;

  // Front stage, digit cells, output register
  localparam int PIPE_LAT = NUM_POS + 2;

  // Reciprocal of ten: q = (x * RECIP10) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [6:0]  SEG_MINUS = 7'h40;
  localparam logic [15:0] POINT_BIT = 16'h0400;

  // Magnitude below this: indicator bytes take positions 5 and 6
  localparam logic [31:0] IND_LIMIT = 32'd100000;

  // Control carried along the cell chain
  typedef struct packed {
    logic       valid;     // transaction present in this stage
    logic       neg;       // minus still to be placed
    logic [2:0] rem;       // digits still to be shown
    logic       is_short;  // magnitude below IND_LIMIT
  } ctrl_t;

  // Decimal digit to segment pattern
  function automatic logic [6:0] digit_seg(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/sdssp_front.sv @@
// Front stage: sign, magnitude and digit count of the incoming value.
module sdssp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic signed [31:0]    value,
  input  logic [15:0]           ind,
  output sdssp_pkg::ctrl_t      ctrl_o,
  output logic [31:0]           mag_o,
  output logic [15:0]           ind_o
);
  import sdssp_pkg::*;

  logic        neg;
  logic [31:0] mag;
  logic [2:0]  count;
  ctrl_t       ctrl_nxt;
  ctrl_t       ctrl_r;
  logic [31:0] mag_r;
  logic [15:0] ind_r;

  // Two's complement magnitude; most negative value stays 2^31
  assign neg = value[31];
  assign mag = neg ? (32'd0 - value) : value;

  // Digit count, at least two
  always_comb begin
    if (mag >= 32'd1000000)     count = 3'd7;
    else if (mag >= 32'd100000) count = 3'd6;
    else if (mag >= 32'd10000)  count = 3'd5;
    else if (mag >= 32'd1000)   count = 3'd4;
    else if (mag >= 32'd100)    count = 3'd3;
    else                        count = 3'd2;
  end

  always_comb begin
    ctrl_nxt.valid    = take;
    ctrl_nxt.neg      = neg;
    ctrl_nxt.rem      = count;
    ctrl_nxt.is_short = (mag < IND_LIMIT);
  end

  // Stage register; only the valid flag is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.valid <= 1'b0;
    end else begin
      ctrl_r.valid <= ctrl_nxt.valid;
    end
    ctrl_r.neg      <= ctrl_nxt.neg;
    ctrl_r.rem      <= ctrl_nxt.rem;
    ctrl_r.is_short <= ctrl_nxt.is_short;
    mag_r           <= mag;
    ind_r           <= ind;
  end

  assign ctrl_o = ctrl_r;
  assign mag_o  = mag_r;
  assign ind_o  = ind_r;

endmodule

@@ hw/rtl/sdssp_digit_cell.sv @@
// Digit cell: peels one decimal digit and shifts its segment pattern in.
module sdssp_digit_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdssp_pkg::ctrl_t              ctrl_i,
  input  logic [31:0]                   quot_i,
  input  logic [sdssp_pkg::SEGS_W-1:0]  segs_i,
  input  logic [15:0]                   ind_i,
  output sdssp_pkg::ctrl_t              ctrl_o,
  output logic [31:0]                   quot_o,
  output logic [sdssp_pkg::SEGS_W-1:0]  segs_o,
  output logic [15:0]                   ind_o
);
  import sdssp_pkg::*;

  logic [63:0]       prod;
  logic [31:0]       quot_nxt;
  logic [31:0]       rem_full;
  logic [3:0]        digit;
  logic [SEG_W-1:0]  seg;
  ctrl_t             ctrl_nxt;
  ctrl_t             ctrl_r;
  logic [31:0]       quot_r;
  logic [SEGS_W-1:0] segs_r;
  logic [15:0]       ind_r;

  // Divide by ten through the reciprocal
  assign prod     = {32'd0, quot_i} * {32'd0, RECIP10};
  assign quot_nxt = {{(RECIP_SHIFT - 32){1'b0}}, prod[63:RECIP_SHIFT]};
  assign rem_full = quot_i - ((quot_nxt << 3) + (quot_nxt << 1));
  assign digit    = rem_full[3:0];

  // Digit, minus just above the top digit, or blank
  always_comb begin
    if (ctrl_i.rem != 3'd0)  seg = digit_seg(digit);
    else if (ctrl_i.neg)     seg = SEG_MINUS;
    else                     seg = '0;
  end

  always_comb begin
    ctrl_nxt          = ctrl_i;
    ctrl_nxt.neg      = ctrl_i.neg && (ctrl_i.rem != 3'd0);
    ctrl_nxt.rem      = (ctrl_i.rem != 3'd0) ? ctrl_i.rem - 3'd1 : 3'd0;
  end

  // Stage register; only the valid flag is reset, newest pattern enters at the top
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.valid <= 1'b0;
    end else begin
      ctrl_r.valid <= ctrl_nxt.valid;
    end
    ctrl_r.neg      <= ctrl_nxt.neg;
    ctrl_r.rem      <= ctrl_nxt.rem;
    ctrl_r.is_short <= ctrl_nxt.is_short;
    quot_r          <= quot_nxt;
    segs_r          <= {seg, segs_i[SEGS_W-1:SEG_W]};
    ind_r           <= ind_i;
  end

  assign ctrl_o = ctrl_r;
  assign quot_o = quot_r;
  assign segs_o = segs_r;
  assign ind_o  = ind_r;

endmodule

@@ hw/rtl/signed_decimal_seven_segment_packer.sv @@
// Top level: front stage, chain of digit cells and output word packing.
//
// Usage:
//   Raise start with in_value and in_indicator_mask; the transaction is
//   taken at that clock edge when busy is low. busy is always low, so a
//   new value can be given in every cycle.
//   Then out_valid is high for one cycle with the four shift
//   words on out_first_word_low .. out_fourth_word.
//   Throughput is one value per cycle; latency is one front stage, seven
//   digit cells (one decimal digit each, via a reciprocal multiply) and
//   the output register.
//   Magnitudes below 100000 show the indicator bytes on positions 5 and 6.
//   The decimal point bit is always set.
//   The receiver cannot stall: each result is shown for exactly one cycle
//   and must be taken then.
//   Synchronous reset (rst_n low) clears all valid flags; transactions in
//   flight are dropped and out_valid stays low until new ones arrive.
module signed_decimal_seven_segment_packer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_value,
  input  logic [15:0]        in_indicator_mask,
  output logic               out_valid,
  output logic [1:0]         out_first_word_low,
  output logic [15:0]        out_second_word,
  output logic [15:0]        out_third_word,
  output logic [15:0]        out_fourth_word
);
  import sdssp_pkg::*;

  ctrl_t             ctrl  [0:NUM_POS];
  logic [31:0]       quot  [0:NUM_POS];
  logic [SEGS_W-1:0] segs  [0:NUM_POS];
  logic [15:0]       ind   [0:NUM_POS];

  logic [SEG_W-1:0]  s0, s1, s2, s3, s4, s5, s6;
  logic [15:0]       w3_full;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [1:0]        w0_r, w0_nxt;
  logic [15:0]       w1_r, w1_nxt;
  logic [15:0]       w2_r, w2_nxt;
  logic [15:0]       w3_r, w3_nxt;

  assign busy = 1'b0;

  // Sign, magnitude and digit count
  sdssp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (start && !busy),
    .value  (in_value),
    .ind    (in_indicator_mask),
    .ctrl_o (ctrl[0]),
    .mag_o  (quot[0]),
    .ind_o  (ind[0])
  );

  assign segs[0] = '0;

  // One cell per display position, lowest first
  for (genvar g = 0; g < NUM_POS; g++) begin : g_cell
    sdssp_digit_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl_i (ctrl[g]),
      .quot_i (quot[g]),
      .segs_i (segs[g]),
      .ind_i  (ind[g]),
      .ctrl_o (ctrl[g+1]),
      .quot_o (quot[g+1]),
      .segs_o (segs[g+1]),
      .ind_o  (ind[g+1])
    );
  end

  // Position patterns after the last cell
  assign s0 = segs[NUM_POS][0*SEG_W +: SEG_W];
  assign s1 = segs[NUM_POS][1*SEG_W +: SEG_W];
  assign s2 = segs[NUM_POS][2*SEG_W +: SEG_W];
  assign s3 = segs[NUM_POS][3*SEG_W +: SEG_W];
  assign s4 = segs[NUM_POS][4*SEG_W +: SEG_W];
  assign s5 = segs[NUM_POS][5*SEG_W +: SEG_W];
  assign s6 = segs[NUM_POS][6*SEG_W +: SEG_W];

  // Scatter into the shift words
  always_comb begin
    out_valid_nxt = ctrl[NUM_POS].valid;
    w0_nxt        = s0[6:5];
    w1_nxt        = {s0[4:0], 1'b0, s1, s2[6:4]} | POINT_BIT;
    w2_nxt        = {s2[3:0], s3, s4[6:2]};
    w3_full       = {s4[1:0], s5, s6};
    if (ctrl[NUM_POS].is_short) begin
      w3_nxt = {s4[1:0], ind[NUM_POS][6:0], ind[NUM_POS][14:8]};
    end else begin
      w3_nxt = w3_full;
    end
  end

  // Output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output words
  always_ff @(posedge clk) begin
    w0_r <= w0_nxt;
    w1_r <= w1_nxt;
    w2_r <= w2_nxt;
    w3_r <= w3_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_first_word_low = w0_r;
  assign out_second_word    = w1_r;
  assign out_third_word     = w2_r;
  assign out_fourth_word    = w3_r;

endmodule

@@ hw/rtl/sdssp_checker.sv @@
// Port-level checker for the seven-segment packer, bound to the top level.
module sdssp_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_value,
  input  logic [15:0]        in_indicator_mask,
  input  logic               out_valid,
  input  logic [1:0]         out_first_word_low,
  input  logic [15:0]        out_second_word,
  input  logic [15:0]        out_third_word,
  input  logic [15:0]        out_fourth_word
);
  import sdssp_pkg::*;

  // Every transaction gives one result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("missing result after transaction");

  // No result without a transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##PIPE_LAT !out_valid)
    else $error("result without transaction");

  // Decimal point is lit in every result
  a_point_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_second_word[10])
    else $error("decimal point not lit");

  // Small non-negative value: indicator bytes take positions 5 and 6
  a_indicator: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_value[31] && (in_value < 32'sd100000)) |->
      ##PIPE_LAT (out_fourth_word[13:7] == $past(in_indicator_mask[6:0], PIPE_LAT)) &&
                 (out_fourth_word[6:0] == $past(in_indicator_mask[14:8], PIPE_LAT)))
    else $error("indicator bytes misplaced");

  // Value zero shows two zero digits
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_value == 32'sd0)) |->
      ##PIPE_LAT (out_second_word == 16'hFDF8) && (out_first_word_low == 2'b01))
    else $error("zero shown wrongly");

endmodule

bind signed_decimal_seven_segment_packer sdssp_checker u_sdssp_checker (.*);
